/* hw/rtl/lrupr_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes and the types that travel along the chain of frame cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

  // Built frame capacity and page number width.
  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;

  // Slot index width; at least one bit even for a single frame.
  localparam int SLOT_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int STAMP_W = 32;

  // Configuration register.
  localparam int              CFG_W    = 5;
  localparam logic [CFG_W-1:0] FC_RESET = 5'd16;

  // Width used to compare the frame count against a slot index.
  localparam int CMP_W = ((SLOT_W > CFG_W) ? SLOT_W : CFG_W) + 1;

  // Stream field widths.
  localparam int IN_PAGE_W   = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_SLOT_W  = 4;
  localparam int FAULT_W     = 32;
  localparam int OUT_FIELD_W = OUT_SLOT_W + FAULT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Search token and partial results handed from one cell to the next.
  typedef struct packed {
    logic               tok;
    logic               found;
    logic [SLOT_W-1:0]  found_slot;
    logic               empty;
    logic [SLOT_W-1:0]  empty_slot;
    logic               have_min;
    logic [STAMP_W-1:0] min_stamp;
    logic [SLOT_W-1:0]  min_slot;
  } srch_t;

  // Frame update broadcast to all cells.
  typedef struct packed {
    logic                 en;
    logic [SLOT_W-1:0]    slot;
    logic [PAGE_BITS-1:0] page;
    logic [STAMP_W-1:0]   stamp;
  } wr_t;

endpackage

`default_nettype wire

/* hw/rtl/lru_page_replacement.sv */
// The search token walks the row of frame cells one cell per cycle; a new
// reference is accepted only after the previous result has moved to the output register.
// Reset (rst_n low, synchronous) clears all valid marks, the use clock and the
// fault count, and sets frame_count to 16.
// ----------------------------------------------------------------------------
// LRU page replacement, top level
// Streams page references through a chain of frame cells and reports hit or
// fault, the slot used and the saturating fault total.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Input stream, tdata: page_number[15:0]
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [lrupr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Result stream, tdata: frame_slot[3:0], fault_total[35:4], zero pad
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [lrupr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Result stream, tuser: hit[0]
  output logic                                 out_tuser,
  // Configuration write, frame_count
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [lrupr_pkg::CFG_W-1:0]          cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DELIV  = 2'd2;

  logic [1:0]                        state_r;
  logic [1:0]                        state_nxt;
  logic [lrupr_pkg::CFG_W-1:0]       frame_count_r;
  logic [lrupr_pkg::PAGE_BITS-1:0]   page_r;
  logic                              launch_r;
  logic [lrupr_pkg::STAMP_W-1:0]     use_clock_r;
  logic [lrupr_pkg::FAULT_W-1:0]     fault_count_r;
  logic [lrupr_pkg::FAULT_W-1:0]     fault_count_nxt;
  logic                              res_hit_r;
  logic [lrupr_pkg::SLOT_W-1:0]      res_slot_r;
  logic                              out_valid_r;
  logic                              out_hit_r;
  logic [lrupr_pkg::OUT_SLOT_W-1:0]  out_slot_r;
  logic [lrupr_pkg::FAULT_W-1:0]     out_fault_r;

  lrupr_pkg::srch_t                  head;
  lrupr_pkg::srch_t                  chain [lrupr_pkg::FRAMES];
  lrupr_pkg::srch_t                  tail;
  lrupr_pkg::wr_t                    wr;
  logic [lrupr_pkg::SLOT_W-1:0]      pick_slot;
  logic                              in_acc;
  logic                              done;
  logic                              deliver;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    head     = '0;
    head.tok = launch_r;
  end

  genvar k;
  generate
    for (k = 0; k < lrupr_pkg::FRAMES; k++) begin : g_cell
      logic act;
      // Slot 0 is always in use; slot k is in use while frame_count exceeds k.
      assign act = (k == 0) ||
                   (lrupr_pkg::CMP_W'(frame_count_r) > lrupr_pkg::CMP_W'(k));
      if (k == 0) begin : g_first
        lrupr_cell u_cell (
          .clk    (clk),
          .rst_n  (rst_n),
          .idx    (lrupr_pkg::SLOT_W'(k)),
          .active (act),
          .page   (page_r),
          .srch_i (head),
          .srch_o (chain[k]),
          .wr     (wr)
        );
      end else begin : g_next
        lrupr_cell u_cell (
          .clk    (clk),
          .rst_n  (rst_n),
          .idx    (lrupr_pkg::SLOT_W'(k)),
          .active (act),
          .page   (page_r),
          .srch_i (chain[k-1]),
          .srch_o (chain[k]),
          .wr     (wr)
        );
      end
    end
  endgenerate

  assign tail = chain[lrupr_pkg::FRAMES-1];
  assign done = (state_r == ST_SEARCH) && tail.tok;

  always_comb begin
    priority if (tail.found) begin
      pick_slot = tail.found_slot;
    end else if (tail.empty) begin
      pick_slot = tail.empty_slot;
    end else begin
      pick_slot = tail.min_slot;
    end
  end

  always_comb begin
    wr.en    = done;
    wr.slot  = pick_slot;
    wr.page  = page_r;
    wr.stamp = use_clock_r;
  end

  always_comb begin
    fault_count_nxt = fault_count_r;
    if (!tail.found && (fault_count_r != lrupr_pkg::FAULT_MAX)) begin
      fault_count_nxt = fault_count_r + 1'b1;
    end
  end

  assign deliver = (state_r == ST_DELIV) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (done) state_nxt = ST_DELIV;
      end
      ST_DELIV: begin
        if (deliver) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frame_count_r <= lrupr_pkg::FC_RESET;
      launch_r      <= 1'b0;
      use_clock_r   <= '0;
      fault_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_acc;
      if (cfg_valid && cfg_ready) begin
        frame_count_r <= cfg_data;
      end
      if (done) begin
        use_clock_r   <= use_clock_r + 1'b1;
        fault_count_r <= fault_count_nxt;
      end
      if (deliver) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r <= lrupr_pkg::PAGE_BITS'(in_tdata);
    end
    if (done) begin
      res_hit_r  <= tail.found;
      res_slot_r <= pick_slot;
    end
    if (deliver) begin
      out_hit_r   <= res_hit_r;
      out_slot_r  <= lrupr_pkg::OUT_SLOT_W'(res_slot_r);
      out_fault_r <= fault_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{lrupr_pkg::OUT_PAD_W{1'b0}}, out_fault_r, out_slot_r};

endmodule

`default_nettype wire

/* hw/rtl/lrupr_cell.sv */
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame (page, valid mark, last-use stamp) and folds its frame into
// the search record that passes through it on the way to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_cell (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [lrupr_pkg::SLOT_W-1:0]   idx,
  input  wire                            active,
  input  wire  [lrupr_pkg::PAGE_BITS-1:0] page,
  input  wire  lrupr_pkg::srch_t         srch_i,
  output lrupr_pkg::srch_t               srch_o,
  input  wire  lrupr_pkg::wr_t           wr
);

  logic [lrupr_pkg::PAGE_BITS-1:0] page_r;
  logic [lrupr_pkg::STAMP_W-1:0]   stamp_r;
  logic                            valid_r;
  lrupr_pkg::srch_t                srch_r;
  lrupr_pkg::srch_t                srch_nxt;

  always_comb begin
    srch_nxt = srch_i;
    if (active && srch_i.tok) begin
      if (!srch_i.found && valid_r && (page_r == page)) begin
        srch_nxt.found      = 1'b1;
        srch_nxt.found_slot = idx;
      end
      if (!srch_i.empty && !valid_r) begin
        srch_nxt.empty      = 1'b1;
        srch_nxt.empty_slot = idx;
      end
      // Strict compare keeps the lower slot on equal stamps.
      if (valid_r && (!srch_i.have_min || (stamp_r < srch_i.min_stamp))) begin
        srch_nxt.have_min  = 1'b1;
        srch_nxt.min_stamp = stamp_r;
        srch_nxt.min_slot  = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      srch_r <= srch_nxt;
      if (wr.en && (wr.slot == idx)) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.slot == idx)) begin
      page_r  <= wr.page;
      stamp_r <= wr.stamp;
    end
  end

  assign srch_o = srch_r;

endmodule

`default_nettype wire

/* hw/rtl/lrupr_chk.sv */
// ----------------------------------------------------------------------------
// LRU page replacement port checker
// Watches the top-level ports for result ordering and fault total behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_chk (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_tvalid,
  input wire                                in_tready,
  input wire [lrupr_pkg::IN_TDATA_W-1:0]    in_tdata,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [lrupr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire                                out_tuser,
  input wire                                cfg_valid,
  input wire                                cfg_ready,
  input wire [lrupr_pkg::CFG_W-1:0]         cfg_data
);

  logic                           in_acc;
  logic                           out_acc;
  logic [2:0]                     pend_r;
  logic                           seen_r;
  logic [lrupr_pkg::FAULT_W-1:0]  last_ft_r;
  logic [lrupr_pkg::FAULT_W-1:0]  ft;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign ft      = out_tdata[lrupr_pkg::OUT_SLOT_W +: lrupr_pkg::FAULT_W];

  // Transactions taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      seen_r <= 1'b0;
    end else begin
      pend_r <= pend_r + {2'b00, in_acc} - {2'b00, out_acc};
      if (out_acc) seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) last_ft_r <= ft;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 3'd0)
    else $error("result without a pending reference");

  a_hit_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r && out_tuser |-> ft == last_ft_r)
    else $error("fault total moved on a hit");

  a_fault_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r && !out_tuser && (last_ft_r != lrupr_pkg::FAULT_MAX)
      |-> ft == last_ft_r + 1'b1)
    else $error("fault total did not advance on a fault");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready || $stable(cfg_data))
    else $error("configuration write dropped");

endmodule

bind lru_page_replacement lrupr_chk u_lrupr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_data   (cfg_data)
);

`default_nettype wire

/* tb/tb_lru_page_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Streams page references into the block and checks each result (hit flag,
// frame slot and fault total) against an LRU frame table kept in the bench.
// The frame count is changed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_lru_page_replacement;

  localparam int SETTLE_CYCLES = lrupr_pkg::FRAMES + 3 + 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic                             hit;
    logic [lrupr_pkg::OUT_SLOT_W-1:0] slot;
    logic [lrupr_pkg::FAULT_W-1:0]    faults;
  } lru_res_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [lrupr_pkg::IN_TDATA_W-1:0]   in_tdata = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [lrupr_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic                               out_tuser;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [lrupr_pkg::CFG_W-1:0]        cfg_data = '0;

  // Frame table mirrored by the bench.
  logic [lrupr_pkg::PAGE_BITS-1:0]    tbl_page [lrupr_pkg::FRAMES];
  logic                               tbl_valid [lrupr_pkg::FRAMES];
  logic [lrupr_pkg::STAMP_W-1:0]      tbl_stamp [lrupr_pkg::FRAMES];
  logic [lrupr_pkg::STAMP_W-1:0]      use_clk;
  logic [lrupr_pkg::FAULT_W-1:0]      fault_cnt;
  logic [lrupr_pkg::CFG_W-1:0]        frame_cnt;

  logic [lrupr_pkg::IN_TDATA_W-1:0]   pending_refs [$];
  lru_res_t                           due_results [$];

  bit                      pace_on = 1'b1;
  bit                      in_fire = 1'b0;
  int unsigned             tx_hold = 0;
  int unsigned             rx_hold = 0;
  int unsigned             quiet_cycles = 0;
  int unsigned             err_count = 0;

  lru_page_replacement u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_frames(input logic [lrupr_pkg::CFG_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > lrupr_pkg::FRAMES) return lrupr_pkg::FRAMES;
    return int'(cnt);
  endfunction

  function automatic void lru_clear();
    for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_page[i]  = '0;
      tbl_stamp[i] = '0;
    end
    use_clk   = '0;
    fault_cnt = '0;
    frame_cnt = lrupr_pkg::FC_RESET;
  endfunction

  // One page reference against the mirrored table: look for the page, else
  // take the first empty frame, else the oldest stamp (lowest slot on ties).
  function automatic lru_res_t lru_access(input logic [lrupr_pkg::PAGE_BITS-1:0] page);
    lru_res_t                      r;
    int                            n;
    int                            s;
    bit                            found;
    bit                            got_empty;
    logic [lrupr_pkg::STAMP_W-1:0] oldest;
    n = active_frames(frame_cnt);
    s = 0;
    found = 1'b0;
    got_empty = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && tbl_valid[i] && tbl_page[i] == page) begin
        s = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      if (fault_cnt != lrupr_pkg::FAULT_MAX) fault_cnt++;
      for (int i = 0; i < n; i++) begin
        if (!got_empty && !tbl_valid[i]) begin
          s = i;
          got_empty = 1'b1;
        end
      end
      if (!got_empty) begin
        oldest = tbl_stamp[0];
        s = 0;
        for (int i = 1; i < n; i++) begin
          if (tbl_stamp[i] < oldest) begin
            oldest = tbl_stamp[i];
            s = i;
          end
        end
      end
      tbl_page[s]  = page;
      tbl_valid[s] = 1'b1;
    end
    tbl_stamp[s] = use_clk;
    use_clk++;
    r.hit    = found;
    r.slot   = lrupr_pkg::OUT_SLOT_W'(s);
    r.faults = fault_cnt;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endtask

  // Page reference driver.
  always @(negedge clk) begin : ref_driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_fire) pending_refs.delete(0);
      if (in_tvalid && !in_fire) begin
        // Transaction still waiting for the block; hold it.
      end else if (tx_hold != 0) begin
        tx_hold--;
        in_tvalid <= 1'b0;
      end else if (pending_refs.size() != 0 && pace_on && $urandom_range(0, 5) == 0) begin
        tx_hold = $urandom_range(1, 13) - 1;
        in_tvalid <= 1'b0;
      end else if (pending_refs.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_refs[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result backpressure.
  always @(negedge clk) begin : result_pacer
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (pace_on && $urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(1, 13) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predicts on every accepted reference and checks every result.
  always @(posedge clk) begin : result_monitor
    lru_res_t                         want;
    logic [lrupr_pkg::OUT_SLOT_W-1:0] got_slot;
    logic [lrupr_pkg::FAULT_W-1:0]    got_faults;
    if (!rst_n) begin
      in_fire = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_fire = in_tvalid && in_tready;
      if (in_fire) due_results.push_back(lru_access(in_tdata));
      if (cfg_valid && cfg_ready) frame_cnt = cfg_data;
      if (out_tvalid && out_tready) begin
        got_slot   = out_tdata[lrupr_pkg::OUT_SLOT_W-1:0];
        got_faults = out_tdata[lrupr_pkg::OUT_SLOT_W +: lrupr_pkg::FAULT_W];
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result hit=%0b slot=%0d faults=%0d",
                                  out_tuser, got_slot, got_faults));
        end else begin
          want = due_results.pop_front();
          if (out_tuser !== want.hit || got_slot !== want.slot || got_faults !== want.faults)
            flag_mismatch($sformatf(
              "result mismatch: expected hit=%0b slot=%0d faults=%0d, got hit=%0b slot=%0d faults=%0d",
              want.hit, want.slot, want.faults, out_tuser, got_slot, got_faults));
        end
      end
      if (in_fire || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  // Waits until every reference has gone in and every result has come out,
  // then lets the block's search pipeline drain.
  task automatic settle();
    while (pending_refs.size() != 0 || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_frame_count(input logic [lrupr_pkg::CFG_W-1:0] cnt);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cnt;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly references from a small working set so that hits and LRU
  // replacements both occur, with some fully random pages mixed in.
  task automatic queue_workload(input int n_refs, input logic [lrupr_pkg::CFG_W-1:0] cnt);
    logic [lrupr_pkg::PAGE_BITS-1:0] pool [$];
    int                              pool_n;
    pool_n = $urandom_range(1, active_frames(cnt) + 4);
    for (int i = 0; i < pool_n; i++) begin
      case ($urandom_range(0, 9))
        0:       pool.push_back('0);
        1:       pool.push_back('1);
        default: pool.push_back(lrupr_pkg::PAGE_BITS'($urandom));
      endcase
    end
    for (int i = 0; i < n_refs; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        pending_refs.push_back(lrupr_pkg::IN_TDATA_W'($urandom));
      end else begin
        pending_refs.push_back(pool[$urandom_range(0, pool_n - 1)]);
      end
    end
  endtask

  initial begin : stimulus
    logic [lrupr_pkg::CFG_W-1:0] cnt;
    lru_clear();
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // All 16 frames after reset: extreme page numbers, hits on resident pages.
    pending_refs = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE, 16'hFFFF};
    settle();
    // A count of zero behaves as a single frame.
    write_frame_count(5'd0);
    pending_refs = '{16'h1234, 16'h1234, 16'h0000, 16'hFFFF};
    settle();
    // A count above the built capacity uses all frames; hidden frames reappear.
    write_frame_count(5'd31);
    pending_refs = '{16'h8001, 16'h0001, 16'hFFFF};
    settle();
    // Two frames: evictions of the least recently used page.
    write_frame_count(5'd2);
    pending_refs = '{16'h0007, 16'h0008, 16'h0007, 16'h0009, 16'h000A};
    settle();
    // Raising the count again exposes frames that kept their pages.
    write_frame_count(5'd16);
    pending_refs = '{16'h7FFE, 16'h0009, 16'h4000};
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       cnt = 5'd1;
        1:       cnt = 5'd16;
        2:       cnt = 5'd31;
        3:       cnt = 5'd0;
        default: cnt = lrupr_pkg::CFG_W'($urandom_range(0, 31));
      endcase
      pace_on = (ph == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
      write_frame_count(cnt);
      queue_workload(60, cnt);
      settle();
    end

    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
